// ===== rtl/elevator_car_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Elevator car controller assertion macros
// Shorthand for the concurrent checks used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_CAR_CONTROLLER_UNIT_MACROS_SVH
`define ELEVATOR_CAR_CONTROLLER_UNIT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define ECC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Clocked check that also runs during reset
`define ECC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/ecc_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator car controller package
// Shared codes and the input word layout.
// ----------------------------------------------------------------------------
package ecc_pkg;

  // Travel direction codes
  typedef enum logic [1:0] {
    DirStop = 2'd0,
    DirUp   = 2'd1,
    DirDown = 2'd2
  } dir_e;

  // Command codes of an input word
  localparam logic [1:0] CmdTick   = 2'd0;
  localparam logic [1:0] CmdCall   = 2'd1;
  localparam logic [1:0] CmdButton = 2'd2;

  // Field widths fixed by the interface
  localparam int FloorFieldW = 4;
  localparam int DoorTimeW   = 4;
  localparam int MapOutW     = 16;

  // One input word
  typedef struct packed {
    logic [1:0]             cmd;
    logic [FloorFieldW-1:0] floor;
    logic                   want_down;
  } ecc_item_t;

endpackage

// ===== rtl/ecc_step.sv =====
// ----------------------------------------------------------------------------
// Elevator car controller decision step
// Next car state for one input word: tick decision and move, hall call and
// car button capture with reject flag.
// ----------------------------------------------------------------------------
module ecc_step #(
  parameter int FLOORS = 16,
  localparam int FW = $clog2(FLOORS)
) (
  input  ecc_pkg::ecc_item_t                item_i,
  input  logic [ecc_pkg::DoorTimeW-1:0]     door_time_i,
  input  logic [FW-1:0]                     cur_floor_i,
  input  ecc_pkg::dir_e                     cur_dir_i,
  input  logic [ecc_pkg::DoorTimeW-1:0]     cur_load_i,
  input  logic [ecc_pkg::DoorTimeW-1:0]     cur_unload_i,
  input  logic [FLOORS-1:0]                 cur_up_i,
  input  logic [FLOORS-1:0]                 cur_down_i,
  input  logic [FLOORS-1:0]                 cur_tgt_i,
  input  logic                              cur_first_i,
  output logic [FW-1:0]                     nxt_floor_o,
  output ecc_pkg::dir_e                     nxt_dir_o,
  output logic [ecc_pkg::DoorTimeW-1:0]     nxt_load_o,
  output logic [ecc_pkg::DoorTimeW-1:0]     nxt_unload_o,
  output logic [FLOORS-1:0]                 nxt_up_o,
  output logic [FLOORS-1:0]                 nxt_down_o,
  output logic [FLOORS-1:0]                 nxt_tgt_o,
  output logic                              nxt_first_o,
  output logic                              rejected_o
);
  import ecc_pkg::*;

  localparam logic [FW-1:0] TopFloor = FW'(FLOORS - 1);
  localparam logic [5:0]    FloorsX  = 6'(FLOORS);
  localparam logic [5:0]    TopX     = 6'(FLOORS - 1);

  // Per-floor masks relative to the car and to the requested floor
  logic [FLOORS-1:0] here, above, below, sel;
  logic [5:0]        req_x, cur_x;
  logic              in_range;

  always_comb begin
    for (int i = 0; i < FLOORS; i++) begin
      here[i]  = (cur_floor_i == FW'(i));
      above[i] = (cur_floor_i < FW'(i));
      below[i] = (cur_floor_i > FW'(i));
      sel[i]   = (req_x == 6'(i));
    end
  end

  assign req_x    = 6'(item_i.floor);
  assign cur_x    = 6'(cur_floor_i);
  assign in_range = (req_x < FloorsX);

  // Decision and update
  always_comb begin
    logic [FW-1:0]          flr;
    dir_e                   dir;
    logic [DoorTimeW-1:0]   ld, ul, start;
    logic [FLOORS-1:0]      up, dn, tg, calls;
    logic                   fp, rej;
    logic                   dest_up, dest_dn, req_up, req_dn;

    flr   = cur_floor_i;
    dir   = cur_dir_i;
    ld    = cur_load_i;
    ul    = cur_unload_i;
    up    = cur_up_i;
    dn    = cur_down_i;
    tg    = cur_tgt_i;
    fp    = cur_first_i;
    rej   = 1'b0;
    start = (door_time_i == '0) ? DoorTimeW'(1) : door_time_i;

    calls   = cur_up_i | cur_down_i;
    dest_up = |(cur_tgt_i & above);
    dest_dn = |(cur_tgt_i & below);
    req_up  = |(calls & above);
    req_dn  = |(calls & below);

    case (item_i.cmd)
      CmdTick: begin
        if (ld != '0) ld = ld - DoorTimeW'(1);
        if (ul != '0) ul = ul - DoorTimeW'(1);
        // stop at the building ends
        if ((flr == TopFloor && dir == DirUp) || (flr == '0 && dir == DirDown)) begin
          dir = DirStop;
        end
        if (|(tg & here)) begin
          tg = tg & ~here;
          if (ul == '0) ul = start;
        end else if (|(up & here) && dir != DirDown) begin
          dir = DirUp;
          up  = up & ~here;
          if (ld == '0) begin
            ld = start;
            fp = 1'b1;
          end
        end else if (|(dn & here) && dir != DirUp) begin
          dir = DirDown;
          dn  = dn & ~here;
          if (ld == '0) begin
            ld = start;
            fp = 1'b1;
          end
        end else if (!dest_up && !dest_dn && !req_up && !req_dn) begin
          dir = DirStop;
        end else if (dest_up && (dir == DirStop || dir == DirUp)) begin
          dir = DirUp;
        end else if (dest_dn && (dir == DirStop || dir == DirDown)) begin
          dir = DirDown;
        end else if (req_up && (dir == DirStop || dir == DirUp)) begin
          dir = DirUp;
        end else if (req_dn && (dir == DirStop || dir == DirDown)) begin
          dir = DirDown;
        end else begin
          dir = DirStop;
        end
        // move one floor when the doors are idle
        if (ld == '0 && ul == '0) begin
          if (dir == DirUp && flr != TopFloor) begin
            flr = flr + FW'(1);
          end else if (dir == DirDown && flr != '0) begin
            flr = flr - FW'(1);
          end
        end
      end
      CmdCall: begin
        if (!in_range || (!item_i.want_down && req_x == TopX) ||
            (item_i.want_down && req_x == '0)) begin
          rej = 1'b1;
        end else if (item_i.want_down) begin
          dn = dn | sel;
        end else begin
          up = up | sel;
        end
      end
      CmdButton: begin
        if (!in_range || ld == '0 || req_x == cur_x) begin
          rej = 1'b1;
        end else begin
          // first pick after loading starts steers a stopped car
          if (fp && dir == DirStop) dir = (req_x < cur_x) ? DirDown : DirUp;
          fp = 1'b0;
          tg = tg | sel;
        end
      end
      default: begin
        rej = 1'b1;
      end
    endcase

    nxt_floor_o  = flr;
    nxt_dir_o    = dir;
    nxt_load_o   = ld;
    nxt_unload_o = ul;
    nxt_up_o     = up;
    nxt_down_o   = dn;
    nxt_tgt_o    = tg;
    nxt_first_o  = fp;
    rejected_o   = rej;
  end

endmodule

// ===== rtl/elevator_car_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Elevator car controller unit
// Single-car controller: input word register, decision step, car state
// registers and a result register.
// ----------------------------------------------------------------------------
// Throughput is one word per clock while the output side takes every result.
// A word is taken into the input register. When the result register is free
// or being taken, one pass of the decision step updates the car state and
// loads the result register. While a result waits to be taken, one more word
// can be taken into an empty input register. After that the input stalls
// until the result is taken. in_ready_o follows out_ready_i combinationally,
// so words flow back to back while the output side takes every result. Every
// word gives exactly one result. There is no clearing pass after reset.
// door_time is written through its own port; the user must write it only
// while the block is idle, as the block does not enforce it; zero acts as one.
module elevator_car_controller_unit #(
  parameter int FLOORS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ecc_pkg::DoorTimeW-1:0]   door_time_i,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      command_i,
  input  logic [ecc_pkg::FloorFieldW-1:0] floor_i,
  input  logic                            want_down_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ecc_pkg::FloorFieldW-1:0] car_floor_o,
  output logic [1:0]                      travel_dir_o,
  output logic [ecc_pkg::DoorTimeW-1:0]   load_count_o,
  output logic [ecc_pkg::DoorTimeW-1:0]   unload_count_o,
  output logic [ecc_pkg::MapOutW-1:0]     up_calls_o,
  output logic [ecc_pkg::MapOutW-1:0]     down_calls_o,
  output logic [ecc_pkg::MapOutW-1:0]     car_targets_o,
  output logic                            rejected_o
);
  import ecc_pkg::*;

  localparam int FW = $clog2(FLOORS);

  // Configuration register
  logic [DoorTimeW-1:0] door_time_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_time_q <= DoorTimeW'(3);
    end else if (cfg_valid_i) begin
      door_time_q <= door_time_i;
    end
  end

  // Input word register
  logic      in_valid_q;
  ecc_item_t item_q;
  logic      step_fire;

  assign step_fire  = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{cmd: command_i, floor: floor_i, want_down: want_down_i};
    end
  end

  // Car state
  logic [FW-1:0]        floor_q, floor_d;
  dir_e                 dir_q, dir_d;
  logic [DoorTimeW-1:0] load_q, load_d, unload_q, unload_d;
  logic [FLOORS-1:0]    up_q, up_d, down_q, down_d, tgt_q, tgt_d;
  logic                 first_q, first_d;
  logic                 rej_d;

  ecc_step #(
    .FLOORS(FLOORS)
  ) u_ecc_step (
    .item_i       (item_q),
    .door_time_i  (door_time_q),
    .cur_floor_i  (floor_q),
    .cur_dir_i    (dir_q),
    .cur_load_i   (load_q),
    .cur_unload_i (unload_q),
    .cur_up_i     (up_q),
    .cur_down_i   (down_q),
    .cur_tgt_i    (tgt_q),
    .cur_first_i  (first_q),
    .nxt_floor_o  (floor_d),
    .nxt_dir_o    (dir_d),
    .nxt_load_o   (load_d),
    .nxt_unload_o (unload_d),
    .nxt_up_o     (up_d),
    .nxt_down_o   (down_d),
    .nxt_tgt_o    (tgt_d),
    .nxt_first_o  (first_d),
    .rejected_o   (rej_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= '0;
      dir_q    <= DirStop;
      load_q   <= '0;
      unload_q <= '0;
      up_q     <= '0;
      down_q   <= '0;
      tgt_q    <= '0;
      first_q  <= 1'b0;
    end else if (step_fire) begin
      floor_q  <= floor_d;
      dir_q    <= dir_d;
      load_q   <= load_d;
      unload_q <= unload_d;
      up_q     <= up_d;
      down_q   <= down_d;
      tgt_q    <= tgt_d;
      first_q  <= first_d;
    end
  end

  // Result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      car_floor_o    <= FloorFieldW'(floor_d);
      travel_dir_o   <= dir_d;
      load_count_o   <= load_d;
      unload_count_o <= unload_d;
      up_calls_o     <= MapOutW'(up_d);
      down_calls_o   <= MapOutW'(down_d);
      car_targets_o  <= MapOutW'(tgt_d);
      rejected_o     <= rej_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/ecc_checker.sv =====
// ----------------------------------------------------------------------------
// Elevator car controller checker
// Port-level checks on the controller, attached by bind.
// ----------------------------------------------------------------------------
`include "elevator_car_controller_unit_macros.svh"

module ecc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [ecc_pkg::FloorFieldW-1:0] car_floor_o,
  input logic [1:0]                      travel_dir_o,
  input logic [ecc_pkg::DoorTimeW-1:0]   load_count_o,
  input logic [ecc_pkg::DoorTimeW-1:0]   unload_count_o,
  input logic [ecc_pkg::MapOutW-1:0]     up_calls_o,
  input logic [ecc_pkg::MapOutW-1:0]     down_calls_o,
  input logic [ecc_pkg::MapOutW-1:0]     car_targets_o,
  input logic                            rejected_o
);

  // stalled result word holds
  `ECC_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(car_floor_o) &&
    $stable(travel_dir_o) && $stable(load_count_o) && $stable(unload_count_o) &&
    $stable(up_calls_o) && $stable(down_calls_o) && $stable(car_targets_o) &&
    $stable(rejected_o), "result word changed while stalled")

  // no result word once reset has been seen at an edge
  `ECC_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o,
    "result valid during reset")

  // input side only blocks behind a stalled result
  `ECC_ASSERT(a_in_block, clk_i, rst_ni,
    !in_ready_o |-> out_valid_o && !out_ready_i, "input blocked without output stall")

  // accepted word passes the input register and reaches the result register when the sink is ready
  `ECC_ASSERT(a_latency, clk_i, rst_ni,
    (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o,
    "accepted word did not produce a result")

  // a down call at the ground floor is never pending
  `ECC_ASSERT(a_no_ground_down, clk_i, rst_ni,
    out_valid_o |-> !down_calls_o[0], "down call pending at ground floor")

endmodule

bind elevator_car_controller_unit ecc_checker u_ecc_checker (.*);
